### design/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

  // Command codes carried with an input beat.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // Register reset values.
  localparam logic [7:0]  HALF_PERIOD_RST = 8'd25;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd500;

  // One input beat: one bus tick.
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One result beat: bus levels and status after the tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic       timed_out;
    logic [7:0] rx_byte;
  } res_t;

endpackage

`default_nettype wire

### design/i2cm_core.sv
// Bus sequencer: phase state, bit timing, shifting and the config registers.
`default_nettype none

module i2cm_core
  import i2cm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire item_t       item_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output res_t             res_o
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_STOP_A   = 4'd3,
    PH_STOP_B   = 4'd4,
    PH_WR_LOW   = 4'd5,
    PH_WR_HIGH  = 4'd6,
    PH_ACK_LOW  = 4'd7,
    PH_ACK_HIGH = 4'd8,
    PH_RD_LOW   = 4'd9,
    PH_RD_HIGH  = 4'd10,
    PH_RA_LOW   = 4'd11,
    PH_RA_HIGH  = 4'd12
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  tick_q, tick_d;
  logic [15:0] wait_q, wait_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        en_q, en_d;
  logic        ack_choice_q, ack_choice_d;
  logic        ack_q, ack_d;
  logic        to_q, to_d;
  logic [7:0]  rx_q, rx_d;
  logic [7:0]  half_q;
  logic [15:0] ack_to_q;

  logic [7:0]  hp;
  logic [8:0]  tick_inc;
  logic        elapsed;
  logic [7:0]  tick_sat;
  logic [16:0] wait_inc;
  logic [3:0]  bit_inc;
  logic [7:0]  shl;
  logic [7:0]  shl_in;
  logic        done;

  // Tick arithmetic shared by all phases.
  always_comb begin
    hp       = (half_q == 8'd0) ? 8'd1 : half_q;
    tick_inc = {1'b0, tick_q} + 9'd1;
    elapsed  = tick_inc >= {1'b0, hp};
    tick_sat = (tick_q < hp) ? tick_inc[7:0] : tick_q;
    wait_inc = {1'b0, wait_q} + 17'd1;
    bit_inc  = bit_q + 4'd1;
    shl      = {shift_q[6:0], 1'b0};
    shl_in   = {shift_q[6:0], item_i.sda_in};
  end

  // Next-state logic for one tick.
  always_comb begin
    phase_d      = phase_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    wait_d       = wait_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    en_d         = en_q;
    ack_choice_d = ack_choice_q;
    ack_d        = ack_q;
    to_d         = to_q;
    rx_d         = rx_q;
    done         = 1'b0;
    tick_d       = (phase_q == PH_IDLE || phase_q == PH_ACK_HIGH) ? tick_q : tick_inc[7:0];

    unique case (phase_q)
      PH_IDLE: begin
        if (item_i.cmd_valid) begin
          to_d   = 1'b0;
          bit_d  = 4'd0;
          tick_d = 8'd0;
          unique case (item_i.command)
            CMD_START: begin
              scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b1;
              phase_d = PH_START_A;
            end
            CMD_STOP: begin
              scl_d = 1'b0; sda_d = 1'b0; en_d = 1'b1;
              phase_d = PH_STOP_A;
            end
            CMD_WRITE: begin
              ack_d   = 1'b0;
              shift_d = item_i.tx_byte;
              scl_d = 1'b0; sda_d = item_i.tx_byte[7]; en_d = 1'b1;
              phase_d = PH_WR_LOW;
            end
            default: begin
              ack_choice_d = item_i.send_ack;
              shift_d      = 8'd0;
              scl_d = 1'b0; sda_d = 1'b1; en_d = 1'b0;
              phase_d = PH_RD_LOW;
            end
          endcase
        end
      end
      PH_ACK_HIGH: begin
        // Poll SDA every tick once the high half has run out.
        tick_d = tick_sat;
        if (tick_sat >= hp) begin
          if (!item_i.sda_in) begin
            ack_d = 1'b1;
            scl_d = 1'b0; sda_d = 1'b1; en_d = 1'b0;
            phase_d = PH_IDLE;
            tick_d  = 8'd0;
            done    = 1'b1;
          end else if (wait_inc > {1'b0, ack_to_q}) begin
            ack_d = 1'b0;
            to_d  = 1'b1;
            scl_d = 1'b0; sda_d = 1'b0; en_d = 1'b1;
            phase_d = PH_STOP_A;
            tick_d  = 8'd0;
          end else begin
            wait_d = wait_inc[15:0];
          end
        end
      end
      PH_START_A: begin
        if (elapsed) begin
          scl_d = 1'b1; sda_d = 1'b0; en_d = 1'b1;
          phase_d = PH_START_B; tick_d = 8'd0;
        end
      end
      PH_START_B: begin
        if (elapsed) begin
          scl_d = 1'b0; sda_d = 1'b0; en_d = 1'b1;
          phase_d = PH_IDLE; tick_d = 8'd0; done = 1'b1;
        end
      end
      PH_STOP_A: begin
        if (elapsed) begin
          scl_d = 1'b1; sda_d = 1'b0; en_d = 1'b1;
          phase_d = PH_STOP_B; tick_d = 8'd0;
        end
      end
      PH_STOP_B: begin
        if (elapsed) begin
          scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b1;
          phase_d = PH_IDLE; tick_d = 8'd0; done = 1'b1;
        end
      end
      PH_WR_LOW: begin
        if (elapsed) begin
          scl_d = 1'b1; en_d = 1'b1;
          phase_d = PH_WR_HIGH; tick_d = 8'd0;
        end
      end
      PH_WR_HIGH: begin
        if (elapsed) begin
          bit_d   = bit_inc;
          shift_d = shl;
          tick_d  = 8'd0;
          if (bit_inc >= 4'd8) begin
            scl_d = 1'b0; sda_d = 1'b1; en_d = 1'b0;
            phase_d = PH_ACK_LOW;
          end else begin
            scl_d = 1'b0; sda_d = shl[7]; en_d = 1'b1;
            phase_d = PH_WR_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        if (elapsed) begin
          scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b0;
          wait_d  = 16'd0;
          phase_d = PH_ACK_HIGH; tick_d = 8'd0;
        end
      end
      PH_RD_LOW: begin
        if (elapsed) begin
          scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b0;
          phase_d = PH_RD_HIGH; tick_d = 8'd0;
        end
      end
      PH_RD_HIGH: begin
        // Sample SDA on the last tick of the high half.
        if (elapsed) begin
          shift_d = shl_in;
          bit_d   = bit_inc;
          tick_d  = 8'd0;
          if (bit_inc >= 4'd8) begin
            scl_d = 1'b0; sda_d = !ack_choice_q; en_d = 1'b1;
            phase_d = PH_RA_LOW;
          end else begin
            scl_d = 1'b0; sda_d = 1'b1; en_d = 1'b0;
            phase_d = PH_RD_LOW;
          end
        end
      end
      PH_RA_LOW: begin
        if (elapsed) begin
          scl_d = 1'b1; en_d = 1'b1;
          phase_d = PH_RA_HIGH; tick_d = 8'd0;
        end
      end
      PH_RA_HIGH: begin
        if (elapsed) begin
          scl_d = 1'b0; en_d = 1'b1;
          rx_d  = shift_q;
          phase_d = PH_IDLE; tick_d = 8'd0; done = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = 8'd0;
      end
    endcase
  end

  // Result of this tick: levels after the update.
  always_comb begin
    res_o.scl_out      = scl_d;
    res_o.sda_out      = en_d ? sda_d : 1'b1;
    res_o.sda_drive    = en_d;
    res_o.busy_res     = phase_d != PH_IDLE;
    res_o.done_res     = done;
    res_o.ack_received = ack_d;
    res_o.timed_out    = to_d;
    res_o.rx_byte      = rx_d;
  end

  // State and config registers; state moves only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_q        <= 4'd0;
      shift_q      <= 8'd0;
      tick_q       <= 8'd0;
      wait_q       <= 16'd0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      en_q         <= 1'b1;
      ack_choice_q <= 1'b0;
      ack_q        <= 1'b0;
      to_q         <= 1'b0;
      rx_q         <= 8'd0;
      half_q       <= HALF_PERIOD_RST;
      ack_to_q     <= ACK_TIMEOUT_RST;
    end else begin
      if (step_i) begin
        phase_q      <= phase_d;
        bit_q        <= bit_d;
        shift_q      <= shift_d;
        tick_q       <= tick_d;
        wait_q       <= wait_d;
        scl_q        <= scl_d;
        sda_q        <= sda_d;
        en_q         <= en_d;
        ack_choice_q <= ack_choice_d;
        ack_q        <= ack_d;
        to_q         <= to_d;
        rx_q         <= rx_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_HALF_PERIOD: half_q   <= cfg_data_i[7:0];
          CFG_ACK_TIMEOUT: ack_to_q <= cfg_data_i;
          default:         ack_to_q <= ack_to_q;
        endcase
      end
    end
  end

  // The sequencer holds still between accepted beats.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(tick_q))
    else $error("phase moved without an accepted beat");

  // A completed command always returns to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == PH_IDLE)
    else $error("done without return to idle");

  // The tick counter is cleared whenever the engine is idle.
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_q == 8'd0)
    else $error("tick counter not cleared in idle");

endmodule

`default_nettype wire

### design/i2cm_outbuf.sv
// Two-entry output register with skid stage between engine and result channel.
`default_nettype none

module i2cm_outbuf
  import i2cm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire res_t res_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      res_o
);

  logic out_vld_q;
  logic skid_vld_q;
  res_t out_q;
  res_t skid_q;
  logic push;
  logic take;

  assign in_stall_o  = skid_vld_q;
  assign push        = in_valid_i && !skid_vld_q;
  assign take        = out_vld_q && !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

  // Control: skid drains into the output register first, keeping order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_i;
      end
    end else if (push) begin
      skid_q <= res_i;
    end
  end

  // The skid entry is only occupied behind a full output register.
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid full while output register empty");

  // A beat arriving behind a stalled result lands in the skid entry.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_vld_q && !take |=> skid_vld_q)
    else $error("beat lost behind stalled result");

  // A drained skid entry moves into the output register.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && take |=> out_vld_q && !skid_vld_q)
    else $error("skid entry not moved forward");

endmodule

`default_nettype wire

### design/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: sequencer plus output buffer.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   cmd_valid, command, tx_byte, send_ack, sda_in
//   out       output     out_valid_o / out_stall_i scl_out .. rx_byte
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each input beat is one bus tick and yields exactly one result beat.
// One beat is accepted every cycle while in_stall_o is low; its result is registered in the output
// register, or in the skid entry behind a stalled result. The sequencer update is combinational between
// the state registers and the output register; a two-entry output buffer absorbs stalls.
// Input stalls only when both output entries hold results.
// Reset is asynchronous and active low; it restores bus idle and default config.
`default_nettype none

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_valid_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  tx_byte_i,
  input  wire logic        send_ack_i,
  input  wire logic        sda_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             scl_out_o,
  output logic             sda_out_o,
  output logic             sda_drive_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic             ack_received_o,
  output logic             timed_out_o,
  output logic [7:0]       rx_byte_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  item_t item;
  res_t  step_res;
  res_t  out_res;
  logic  accept;

  // Input beat assembly and acceptance.
  assign item.cmd_valid = cmd_valid_i;
  assign item.command   = command_i;
  assign item.tx_byte   = tx_byte_i;
  assign item.send_ack  = send_ack_i;
  assign item.sda_in    = sda_in_i;
  assign accept         = in_valid_i && !in_stall_o;
  assign cfg_ready_o    = 1'b1;

  i2cm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .item_i      (item),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (step_res)
  );

  i2cm_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .res_i       (step_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  // Result beat fields.
  assign scl_out_o      = out_res.scl_out;
  assign sda_out_o      = out_res.sda_out;
  assign sda_drive_o    = out_res.sda_drive;
  assign busy_res_o     = out_res.busy_res;
  assign done_res_o     = out_res.done_res;
  assign ack_received_o = out_res.ack_received;
  assign timed_out_o    = out_res.timed_out;
  assign rx_byte_o      = out_res.rx_byte;

endmodule

`default_nettype wire

### test/tb_i2c_master_byte_engine.sv
// Testbench for the I2C master byte engine: directed bus operations, then random transfers.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TICK_TARGET = 1650;

  // Sequencer states of the engine, as the checker tracks them.
  typedef enum logic [3:0] {
    ST_IDLE, ST_START_A, ST_START_B, ST_STOP_A, ST_STOP_B, ST_WR_LOW, ST_WR_HIGH,
    ST_ACK_LOW, ST_ACK_HIGH, ST_RD_LOW, ST_RD_HIGH, ST_RA_LOW, ST_RA_HIGH
  } engine_state_e;

  // One directed bus operation, with optional register writes ahead of it.
  typedef struct {
    int         hp;
    int         tmo;
    logic       issue;
    logic [1:0] cmd;
    logic [7:0] data;
    logic       ack;
    logic [7:0] reply;
    int         ack_after;
    logic       pin;
    logic       exp_ack;
    logic       exp_to;
    logic [7:0] exp_rx;
  } bus_op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_valid_i = 1'b0;
  logic [1:0]  command_i = CMD_START;
  logic [7:0]  tx_byte_i = 8'h00;
  logic        send_ack_i = 1'b0;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        sda_drive_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        ack_received_o;
  logic        timed_out_o;
  logic [7:0]  rx_byte_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_HALF_PERIOD;
  logic [15:0] cfg_data_i = 16'h0000;

  // Engine state as predicted from the accepted ticks.
  engine_state_e state_q;
  logic [3:0]    bit_cnt;
  logic [7:0]    shifter;
  logic [7:0]    ticks;
  logic [15:0]   ack_polls;
  logic          scl_lvl;
  logic          sda_lvl;
  logic          sda_en;
  logic          send_ack_q;
  logic          ack_seen;
  logic          timeout_seen;
  logic [7:0]    rx_last;
  logic [7:0]    hp_reg;
  logic [15:0]   to_reg;

  // Slave behavior for the operation in progress.
  logic [7:0] slave_byte;
  int         slave_ack_after;

  // Pinned status values for the completing tick of a directed row.
  logic       pin_on = 1'b0;
  logic       pin_ack;
  logic       pin_to;
  logic [7:0] pin_rx;

  res_t    pending_ticks[$];
  bus_op_t plan[19];
  bit      calm = 1'b0;
  int      ticks_sent = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      cycles = 0;

  i2c_master_byte_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_valid_i   (cmd_valid_i),
    .command_i     (command_i),
    .tx_byte_i     (tx_byte_i),
    .send_ack_i    (send_ack_i),
    .sda_in_i      (sda_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_out_o     (scl_out_o),
    .sda_out_o     (sda_out_o),
    .sda_drive_o   (sda_drive_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .ack_received_o(ack_received_o),
    .timed_out_o   (timed_out_o),
    .rx_byte_o     (rx_byte_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Effective half period: zero behaves as one tick.
  function automatic logic [7:0] half_ticks();
    return (hp_reg == 8'd0) ? 8'd1 : hp_reg;
  endfunction

  function automatic void put_bus(logic scl, logic sda, logic drv);
    scl_lvl = scl;
    sda_en  = drv;
    sda_lvl = drv ? sda : 1'b1;
  endfunction

  function automatic void enter_state(engine_state_e s);
    state_q = s;
    ticks   = 8'd0;
  endfunction

  // Advance the predicted engine by one bus tick and return its output levels.
  function automatic res_t engine_tick(item_t it);
    logic [7:0]  hp;
    logic        done;
    logic        elapsed;
    logic [16:0] polls_next;
    res_t        r;
    hp      = half_ticks();
    done    = 1'b0;
    elapsed = 1'b0;
    if (state_q == ST_IDLE) begin
      if (it.cmd_valid) begin
        timeout_seen = 1'b0;
        bit_cnt      = 4'd0;
        case (it.command)
          CMD_START: begin
            put_bus(1'b1, 1'b1, 1'b1);
            enter_state(ST_START_A);
          end
          CMD_STOP: begin
            put_bus(1'b0, 1'b0, 1'b1);
            enter_state(ST_STOP_A);
          end
          CMD_WRITE: begin
            ack_seen = 1'b0;
            shifter  = it.tx_byte;
            put_bus(1'b0, shifter[7], 1'b1);
            enter_state(ST_WR_LOW);
          end
          default: begin
            send_ack_q = it.send_ack;
            shifter    = 8'h00;
            put_bus(1'b0, 1'b1, 1'b0);
            enter_state(ST_RD_LOW);
          end
        endcase
      end
    end else if (state_q == ST_ACK_HIGH) begin
      // Poll SDA every tick once the acknowledge clock has been high long enough.
      if (ticks < hp) ticks = ticks + 8'd1;
      if (ticks >= hp) begin
        if (!it.sda_in) begin
          ack_seen = 1'b1;
          put_bus(1'b0, 1'b1, 1'b0);
          enter_state(ST_IDLE);
          done = 1'b1;
        end else begin
          polls_next = {1'b0, ack_polls} + 17'd1;
          if (polls_next > {1'b0, to_reg}) begin
            ack_seen     = 1'b0;
            timeout_seen = 1'b1;
            put_bus(1'b0, 1'b0, 1'b1);
            enter_state(ST_STOP_A);
          end else begin
            ack_polls = polls_next[15:0];
          end
        end
      end
    end else begin
      ticks   = ticks + 8'd1;
      elapsed = ticks >= hp;
    end

    // Half period over: move to the next bus level.
    if (elapsed) begin
      case (state_q)
        ST_START_A: begin
          put_bus(1'b1, 1'b0, 1'b1);
          enter_state(ST_START_B);
        end
        ST_START_B: begin
          put_bus(1'b0, 1'b0, 1'b1);
          enter_state(ST_IDLE);
          done = 1'b1;
        end
        ST_STOP_A: begin
          put_bus(1'b1, 1'b0, 1'b1);
          enter_state(ST_STOP_B);
        end
        ST_STOP_B: begin
          put_bus(1'b1, 1'b1, 1'b1);
          enter_state(ST_IDLE);
          done = 1'b1;
        end
        ST_WR_LOW: begin
          put_bus(1'b1, sda_lvl, 1'b1);
          enter_state(ST_WR_HIGH);
        end
        ST_WR_HIGH: begin
          bit_cnt = bit_cnt + 4'd1;
          shifter = shifter << 1;
          if (bit_cnt >= 4'd8) begin
            put_bus(1'b0, 1'b1, 1'b0);
            enter_state(ST_ACK_LOW);
          end else begin
            put_bus(1'b0, shifter[7], 1'b1);
            enter_state(ST_WR_LOW);
          end
        end
        ST_ACK_LOW: begin
          put_bus(1'b1, 1'b1, 1'b0);
          ack_polls = 16'd0;
          enter_state(ST_ACK_HIGH);
        end
        ST_RD_LOW: begin
          put_bus(1'b1, 1'b1, 1'b0);
          enter_state(ST_RD_HIGH);
        end
        ST_RD_HIGH: begin
          shifter = {shifter[6:0], it.sda_in};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            put_bus(1'b0, !send_ack_q, 1'b1);
            enter_state(ST_RA_LOW);
          end else begin
            put_bus(1'b0, 1'b1, 1'b0);
            enter_state(ST_RD_LOW);
          end
        end
        ST_RA_LOW: begin
          put_bus(1'b1, sda_lvl, 1'b1);
          enter_state(ST_RA_HIGH);
        end
        ST_RA_HIGH: begin
          put_bus(1'b0, sda_lvl, 1'b1);
          rx_last = shifter;
          enter_state(ST_IDLE);
          done = 1'b1;
        end
        default: enter_state(ST_IDLE);
      endcase
    end

    r.scl_out      = scl_lvl;
    r.sda_out      = sda_en ? sda_lvl : 1'b1;
    r.sda_drive    = sda_en;
    r.busy_res     = state_q != ST_IDLE;
    r.done_res     = done;
    r.ack_received = ack_seen;
    r.timed_out    = timeout_seen;
    r.rx_byte      = rx_last;
    return r;
  endfunction

  // SDA as the slave drives it on the coming tick: read data on the sampling
  // tick, acknowledge after the chosen number of polls, noise elsewhere.
  function automatic logic slave_sda();
    case (state_q)
      ST_RD_HIGH:
        return (ticks + 8'd1 >= half_ticks()) ? slave_byte[3'd7 - bit_cnt[2:0]] : 1'($urandom);
      ST_ACK_HIGH:
        return !(slave_ack_after >= 0 && int'(ack_polls) >= slave_ack_after);
      default:
        return 1'($urandom);
    endcase
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Acknowledge delay in polls; never acknowledging only where the timeout is short.
  function automatic int pick_ack_after();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0 && to_reg <= 16'd40) return -1;
    return $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  // Present one tick beat, hold it until accepted, and record its expected result.
  task automatic send_tick(input item_t it, output res_t r);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_valid_i <= it.cmd_valid;
    command_i   <= it.command;
    tx_byte_i   <= it.tx_byte;
    send_ack_i  <= it.send_ack;
    sda_in_i    <= it.sda_in;
    do @(posedge clk_i); while (in_stall_o);
    r = engine_tick(it);
    if (pin_on && !r.busy_res) begin
      r.ack_received = pin_ack;
      r.timed_out    = pin_to;
      r.rx_byte      = pin_rx;
    end
    pending_ticks.push_back(r);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Issue one command from idle and keep ticking until it completes.
  task automatic bus_op(input logic issue, input logic [1:0] cmd, input logic [7:0] data,
                        input logic ack, input logic [7:0] reply, input int ack_after);
    item_t it;
    res_t  r;
    slave_byte      = reply;
    slave_ack_after = ack_after;
    it.cmd_valid    = issue;
    it.command      = cmd;
    it.tx_byte      = data;
    it.send_ack     = ack;
    it.sda_in       = slave_sda();
    send_tick(it, r);
    while (issue && !r.done_res) begin
      // Commands offered while busy must be ignored.
      it.cmd_valid = ($urandom_range(0, 7) == 0);
      it.command   = 2'($urandom);
      it.tx_byte   = 8'($urandom);
      it.send_ack  = 1'($urandom);
      it.sda_in    = slave_sda();
      send_tick(it, r);
    end
  endtask

  // Drop valid and wait until every expected beat has come back.
  task automatic hold_sender_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_ticks.size() != 0);
  endtask

  task automatic load_cfg(input logic idx, input logic [15:0] data);
    hold_sender_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_HALF_PERIOD) hp_reg = data[7:0];
    else to_reg = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver stalls, with calm stretches that have none.
  initial begin : stall_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each result beat with the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.scl_out      = scl_out_o;
      got.sda_out      = sda_out_o;
      got.sda_drive    = sda_drive_o;
      got.busy_res     = busy_res_o;
      got.done_res     = done_res_o;
      got.ack_received = ack_received_o;
      got.timed_out    = timed_out_o;
      got.rx_byte      = rx_byte_o;
      if (pending_ticks.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_ticks.pop_front();
        if (got.scl_out !== want.scl_out)
          report_mismatch($sformatf("scl_out %b, expected %b", got.scl_out, want.scl_out));
        if (got.sda_out !== want.sda_out)
          report_mismatch($sformatf("sda_out %b, expected %b", got.sda_out, want.sda_out));
        if (got.sda_drive !== want.sda_drive)
          report_mismatch($sformatf("sda_drive %b, expected %b", got.sda_drive, want.sda_drive));
        if (got.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
        if (got.ack_received !== want.ack_received)
          report_mismatch($sformatf("ack_received %b, expected %b",
                                    got.ack_received, want.ack_received));
        if (got.timed_out !== want.timed_out)
          report_mismatch($sformatf("timed_out %b, expected %b", got.timed_out, want.timed_out));
        if (got.rx_byte !== want.rx_byte)
          report_mismatch($sformatf("rx_byte %h, expected %h", got.rx_byte, want.rx_byte));
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int         roll;
    int         n;
    bit         pressed;
    logic [7:0] addr;
    logic [7:0] hp_val;
    logic [15:0] to_val;

    // Predicted state after reset.
    state_q      = ST_IDLE;
    bit_cnt      = 4'd0;
    shifter      = 8'h00;
    ticks        = 8'd0;
    ack_polls    = 16'd0;
    scl_lvl      = 1'b1;
    sda_lvl      = 1'b1;
    sda_en       = 1'b1;
    send_ack_q   = 1'b0;
    ack_seen     = 1'b0;
    timeout_seen = 1'b0;
    rx_last      = 8'h00;
    hp_reg       = HALF_PERIOD_RST;
    to_reg       = ACK_TIMEOUT_RST;
    pressed      = 1'b0;

    // Directed rows: hp, timeout, issue, command, byte, ack, slave byte, ack delay,
    // then pinned ack_received, timed_out and rx_byte where they are obvious.
    plan = '{
      // idle tick right after reset
      '{-1, -1, 1'b0, CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b1, 1'b0, 1'b0, 8'h00},
      // start and stop at the reset half period
      '{-1, -1, 1'b1, CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{-1, -1, 1'b1, CMD_STOP, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{1, 3, 1'b1, CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      // writes: prompt ack, ack on the last allowed poll, no ack at all
      '{-1, -1, 1'b1, CMD_WRITE, 8'hFF, 1'b0, 8'h00, 0, 1'b1, 1'b1, 1'b0, 8'h00},
      '{-1, -1, 1'b1, CMD_WRITE, 8'h00, 1'b1, 8'h00, 3, 1'b1, 1'b1, 1'b0, 8'h00},
      '{-1, -1, 1'b1, CMD_WRITE, 8'hA5, 1'b0, 8'h00, -1, 1'b1, 1'b0, 1'b1, 8'h00},
      // reads with ACK and with NACK on the last byte
      '{-1, -1, 1'b1, CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{-1, -1, 1'b1, CMD_READ, 8'h00, 1'b1, 8'hFF, 0, 1'b1, 1'b0, 1'b0, 8'hFF},
      '{-1, -1, 1'b1, CMD_READ, 8'hFF, 1'b0, 8'h00, 0, 1'b1, 1'b0, 1'b0, 8'h00},
      '{-1, -1, 1'b1, CMD_STOP, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      // zero half period and zero timeout
      '{0, 0, 1'b1, CMD_WRITE, 8'h3C, 1'b0, 8'h00, -1, 1'b1, 1'b0, 1'b1, 8'h00},
      '{-1, -1, 1'b1, CMD_WRITE, 8'hC3, 1'b1, 8'h00, 0, 1'b1, 1'b1, 1'b0, 8'h00},
      // commands out of bus order
      '{-1, -1, 1'b1, CMD_READ, 8'h00, 1'b1, 8'h5A, 0, 1'b1, 1'b1, 1'b0, 8'h5A},
      '{-1, -1, 1'b1, CMD_STOP, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      // largest half period and timeout
      '{255, 65535, 1'b1, CMD_START, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{2, -1, 1'b1, CMD_WRITE, 8'h81, 1'b0, 8'h00, 5, 1'b1, 1'b1, 1'b0, 8'h5A},
      '{-1, -1, 1'b1, CMD_READ, 8'h00, 1'b0, 8'h96, 0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{-1, -1, 1'b1, CMD_STOP, 8'h00, 1'b0, 8'h00, 0, 1'b0, 1'b0, 1'b0, 8'h00}
    };

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    for (int i = 0; i < 19; i++) begin
      if (plan[i].hp >= 0) load_cfg(CFG_HALF_PERIOD, 16'(plan[i].hp));
      if (plan[i].tmo >= 0) load_cfg(CFG_ACK_TIMEOUT, 16'(plan[i].tmo));
      pin_on  = plan[i].pin;
      pin_ack = plan[i].exp_ack;
      pin_to  = plan[i].exp_to;
      pin_rx  = plan[i].exp_rx;
      bus_op(plan[i].issue, plan[i].cmd, plan[i].data, plan[i].ack, plan[i].reply,
             plan[i].ack_after);
      pin_on = 1'b0;
    end

    // Random part: mostly well-formed transfers, some lone or misplaced commands.
    while (ticks_sent < TICK_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) hp_val = 8'd0;
        else if (roll < 7) hp_val = 8'd1;
        else if (roll < 9) hp_val = 8'($urandom_range(2, 3));
        else hp_val = 8'($urandom_range(4, 6));
        load_cfg(CFG_HALF_PERIOD, {8'($urandom), hp_val});
        if ($urandom_range(0, 9) < 8) to_val = 16'($urandom_range(0, 6));
        else to_val = 16'($urandom);
        load_cfg(CFG_ACK_TIMEOUT, to_val);
      end
      calm = ($urandom_range(0, 5) == 0);

      // Once midway the sender waits for the pipeline to empty.
      if (!pressed && ticks_sent > TICK_TARGET / 2) begin
        pressed = 1'b1;
        hold_sender_until_drained();
      end

      if ($urandom_range(0, 9) < 7) begin
        addr = 8'($urandom);
        bus_op(1'b1, CMD_START, 8'($urandom), 1'($urandom), 8'($urandom), 0);
        bus_op(1'b1, CMD_WRITE, addr, 1'($urandom), 8'($urandom), pick_ack_after());
        // A timed out address already ended with a stop.
        if (!timeout_seen) begin
          if (!addr[0] && $urandom_range(0, 2) == 0) begin
            // Register pointer write, then repeated start into a read.
            bus_op(1'b1, CMD_WRITE, 8'($urandom), 1'($urandom), 8'($urandom),
                   pick_ack_after());
            if (!timeout_seen) begin
              bus_op(1'b1, CMD_START, 8'($urandom), 1'($urandom), 8'($urandom), 0);
              bus_op(1'b1, CMD_WRITE, addr | 8'h01, 1'($urandom), 8'($urandom),
                     pick_ack_after());
              addr[0] = 1'b1;
            end
          end
          n = $urandom_range(1, 3);
          for (int k = 0; k < n && !timeout_seen; k++) begin
            if (addr[0])
              bus_op(1'b1, CMD_READ, 8'($urandom), k != n - 1, 8'($urandom), 0);
            else
              bus_op(1'b1, CMD_WRITE, 8'($urandom), 1'($urandom), 8'($urandom),
                     pick_ack_after());
          end
          if (!timeout_seen)
            bus_op(1'b1, CMD_STOP, 8'($urandom), 1'($urandom), 8'($urandom), 0);
        end
      end else begin
        bus_op(1'b1, 2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
               pick_ack_after());
      end
    end

    // Drain, let the output settle, then report.
    calm = 1'b0;
    hold_sender_until_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
design/i2cm_pkg.sv
design/i2cm_core.sv
design/i2cm_outbuf.sv
design/i2c_master_byte_engine.sv
test/tb_i2c_master_byte_engine.sv
